// ===== rtl/hrfp_pkg.sv =====
// Shared types and constants for the hex request frame parser.
package hrfp_pkg;

    localparam int unsigned FRAME_CHARS = 14;
    localparam int unsigned POS_W       = 4;

    // Field boundaries (character positions within a frame)
    localparam logic [POS_W-1:0] POS_SRV_END = 4'd1;
    localparam logic [POS_W-1:0] POS_FUN_END = 4'd3;
    localparam logic [POS_W-1:0] POS_REG_BEG = 4'd4;
    localparam logic [POS_W-1:0] POS_REG_END = 4'd7;
    localparam logic [POS_W-1:0] POS_CNT_BEG = 4'd8;
    localparam logic [POS_W-1:0] POS_CNT_END = 4'd11;
    localparam logic [POS_W-1:0] POS_CHK_BEG = 4'd12;
    localparam logic [POS_W-1:0] POS_SRV_BEG = 4'd0;
    localparam logic [POS_W-1:0] POS_FUN_BEG = 4'd2;
    localparam logic [POS_W-1:0] POS_LAST    = POS_W'(FRAME_CHARS - 1);
    localparam logic [POS_W-1:0] POS_DONE    = POS_W'(FRAME_CHARS);

    // ASCII codes
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_F = 8'h46;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_F = 8'h66;
    localparam logic [7:0] HEX_TEN    = 8'd10;

    typedef struct packed {
        logic [7:0] char_code;
        logic       frame_start;
    } t_hrfp_in;

    typedef struct packed {
        logic [7:0]  server_addr;
        logic [7:0]  function_code;
        logic [15:0] start_register;
        logic [15:0] register_count;
        logic [7:0]  check_byte;
    } t_hrfp_out;

    typedef struct packed {
        logic [3:0] nib;
        logic       ok;
    } t_hrfp_nib;

endpackage

// ===== rtl/hex_request_frame_parser.sv =====
// Top level: parses a hex character stream into request frame fields.
//
//  channel | direction | handshake               | word
//  --------+-----------+-------------------------+-----------------------------
//  in      | sink      | i_in_valid / o_in_ready | char_code, frame_start
//  out     | source    | o_out_valid/i_out_ready | five decoded frame fields
//
// One character per cycle; the result of the 14th character shows on the
// output register the cycle after it is taken.
// Throughput is set by the single output register: input stalls only while
// a result sits there and is not being taken.
// Reset (synchronous, active low) clears position, field state and output valid.
// Characters after the 14th are absorbed without a result until frame_start.
module hex_request_frame_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  hrfp_pkg::t_hrfp_in  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output hrfp_pkg::t_hrfp_out o_out_data
);
    import hrfp_pkg::*;

    logic [POS_W-1:0] r_pos,  n_pos;
    logic [15:0]      r_acc,  n_acc;
    logic             r_bad,  n_bad;
    logic [7:0]       r_srv,  n_srv;
    logic [7:0]       r_fun,  n_fun;
    logic [15:0]      r_reg,  n_reg;
    logic [15:0]      r_cnt,  n_cnt;
    logic             r_ovld, n_ovld;
    t_hrfp_out        r_out,  n_out;

    logic             w_in_fire;
    logic             w_last;
    logic [POS_W-1:0] w_pos;
    logic             w_first;
    logic [15:0]      w_acc_base;
    logic [15:0]      w_value;
    t_hrfp_nib        w_dec;

    hrfp_nibble_dec u_dec (
        .i_char (i_in_data.char_code),
        .o_dec  (w_dec)
    );

    assign o_in_ready  = !r_ovld || i_out_ready;
    assign w_in_fire   = i_in_valid && o_in_ready;
    assign o_out_valid = r_ovld;
    assign o_out_data  = r_out;

    always_comb begin
        w_pos      = i_in_data.frame_start ? '0 : r_pos;
        w_first    = w_pos inside {POS_SRV_BEG, POS_FUN_BEG, POS_REG_BEG,
                                   POS_CNT_BEG, POS_CHK_BEG};
        w_acc_base = w_first ? 16'd0 : r_acc;
        w_last     = (w_pos == POS_LAST);

        n_pos  = r_pos;
        n_acc  = r_acc;
        n_bad  = r_bad;
        n_srv  = r_srv;
        n_fun  = r_fun;
        n_reg  = r_reg;
        n_cnt  = r_cnt;
        n_out  = r_out;
        n_ovld = r_ovld && !i_out_ready;

        n_acc   = {w_acc_base[11:0], w_dec.nib};
        n_bad   = (r_bad && !w_first) || !w_dec.ok;
        w_value = n_bad ? 16'd0 : n_acc;

        if (w_in_fire) begin
            n_pos = w_pos;
            if (w_pos < POS_DONE) begin
                n_pos = w_pos + POS_W'(1);
                case (w_pos)
                    POS_SRV_END: n_srv = w_value[7:0];
                    POS_FUN_END: n_fun = w_value[7:0];
                    POS_REG_END: n_reg = w_value;
                    POS_CNT_END: n_cnt = w_value;
                    default:     ;
                endcase
                if (w_last) begin
                    n_ovld               = 1'b1;
                    n_out.server_addr    = r_srv;
                    n_out.function_code  = r_fun;
                    n_out.start_register = r_reg;
                    n_out.register_count = r_cnt;
                    n_out.check_byte     = w_value[7:0];
                end
            end else begin
                n_acc = r_acc;
                n_bad = r_bad;
            end
        end else begin
            n_acc = r_acc;
            n_bad = r_bad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_acc  <= '0;
            r_bad  <= 1'b0;
            r_srv  <= '0;
            r_fun  <= '0;
            r_reg  <= '0;
            r_cnt  <= '0;
            r_ovld <= 1'b0;
        end else begin
            r_pos  <= n_pos;
            r_acc  <= n_acc;
            r_bad  <= n_bad;
            r_srv  <= n_srv;
            r_fun  <= n_fun;
            r_reg  <= n_reg;
            r_cnt  <= n_cnt;
            r_ovld <= n_ovld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

`ifndef ASSERT_OFF
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_DONE)
        else $error("frame position out of range");

    a_result_from_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_in_fire))
        else $error("result appeared without an accepted word");

    a_done_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && w_last) |=> (r_pos == POS_DONE) && o_out_valid)
        else $error("last character did not complete the frame");
`endif

endmodule

// ===== rtl/hrfp_nibble_dec.sv =====
// ASCII hex character to nibble decoder.
module hrfp_nibble_dec (
    input  logic [7:0]         i_char,
    output hrfp_pkg::t_hrfp_nib o_dec
);
    import hrfp_pkg::*;

    logic [7:0] w_diff;

    always_comb begin
        w_diff = 8'd0;
        o_dec  = '0;
        if (i_char inside {[CH_DIGIT_0:CH_DIGIT_9]}) begin
            w_diff    = i_char - CH_DIGIT_0;
            o_dec.ok  = 1'b1;
        end else if (i_char inside {[CH_UPPER_A:CH_UPPER_F]}) begin
            w_diff    = i_char - CH_UPPER_A + HEX_TEN;
            o_dec.ok  = 1'b1;
        end else if (i_char inside {[CH_LOWER_A:CH_LOWER_F]}) begin
            w_diff    = i_char - CH_LOWER_A + HEX_TEN;
            o_dec.ok  = 1'b1;
        end
        o_dec.nib = w_diff[3:0];
    end

endmodule

// ===== tb/sv/tb_hex_request_frame_parser.sv =====
// Testbench for the hex request frame parser: random and directed frames, scoreboard check.
`timescale 1ns / 100ps

module tb_hex_request_frame_parser;

    import hrfp_pkg::*;

    localparam int STALL_LIMIT   = 2000;
    localparam int LONG_HOLD     = 80;
    localparam int HOLD_AFTER    = 150;
    localparam int RANDOM_WORDS  = 700;
    localparam int QUIET_AFTER   = 600;
    localparam int MIN_FRAMES    = 40;
    localparam int DRAIN_CYCLES  = 10;
    localparam int REPORT_LIMIT  = 10;

    // characters just outside the hex ranges
    localparam logic [7:0] NEAR_HEX [6] = '{8'h2F, 8'h3A, 8'h40, 8'h47, 8'h60, 8'h67};

    // Field predictor and store of decoded frames still owed by the block.
    class hrfp_frame_checker;
        logic [POS_W-1:0] char_pos;
        logic [15:0]      field_acc;
        logic             field_bad;
        logic [7:0]       srv_hold;
        logic [7:0]       fun_hold;
        logic [15:0]      reg_hold;
        logic [15:0]      cnt_hold;
        t_hrfp_out        frames_due[$];
        int               fail_count;

        function new();
            char_pos   = '0;
            field_acc  = '0;
            field_bad  = 1'b0;
            srv_hold   = '0;
            fun_hold   = '0;
            reg_hold   = '0;
            cnt_hold   = '0;
            fail_count = 0;
        endfunction

        function bit decode_char(input logic [7:0] c, output logic [3:0] nib);
            nib = '0;
            if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
                nib = 4'(c - CH_DIGIT_0);
                return 1'b1;
            end
            if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
                nib = 4'(c - CH_UPPER_A + HEX_TEN);
                return 1'b1;
            end
            if (c >= CH_LOWER_A && c <= CH_LOWER_F) begin
                nib = 4'(c - CH_LOWER_A + HEX_TEN);
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void note_word(input t_hrfp_in w);
            logic [3:0]  nib;
            logic        ok;
            logic [15:0] value;
            t_hrfp_out   f;
            if (w.frame_start)
                char_pos = '0;
            if (char_pos >= POS_DONE)
                return;
            if (char_pos == POS_SRV_BEG || char_pos == POS_FUN_BEG || char_pos == POS_REG_BEG ||
                char_pos == POS_CNT_BEG || char_pos == POS_CHK_BEG) begin
                field_acc = '0;
                field_bad = 1'b0;
            end
            ok = decode_char(w.char_code, nib);
            field_acc = {field_acc[11:0], nib};
            if (!ok)
                field_bad = 1'b1;
            value = field_bad ? 16'h0 : field_acc;
            case (char_pos)
                POS_SRV_END: srv_hold = value[7:0];
                POS_FUN_END: fun_hold = value[7:0];
                POS_REG_END: reg_hold = value;
                POS_CNT_END: cnt_hold = value;
                default: ;
            endcase
            if (char_pos == POS_LAST) begin
                f.server_addr    = srv_hold;
                f.function_code  = fun_hold;
                f.start_register = reg_hold;
                f.register_count = cnt_hold;
                f.check_byte     = value[7:0];
                frames_due.push_back(f);
            end
            char_pos = char_pos + POS_W'(1);
        endfunction

        function void flag(input string what, input logic [15:0] exp_v, input logic [15:0] got_v);
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
                $display("%0t mismatch %s: expected %h, got %h", $realtime, what, exp_v, got_v);
        endfunction

        function void check_frame(input t_hrfp_out got);
            t_hrfp_out exp_f;
            if (frames_due.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("%0t unexpected result word %h", $realtime, got);
                return;
            end
            exp_f = frames_due.pop_front();
            if (got.server_addr !== exp_f.server_addr)
                flag("server_addr", 16'(exp_f.server_addr), 16'(got.server_addr));
            if (got.function_code !== exp_f.function_code)
                flag("function_code", 16'(exp_f.function_code), 16'(got.function_code));
            if (got.start_register !== exp_f.start_register)
                flag("start_register", exp_f.start_register, got.start_register);
            if (got.register_count !== exp_f.register_count)
                flag("register_count", exp_f.register_count, got.register_count);
            if (got.check_byte !== exp_f.check_byte)
                flag("check_byte", 16'(exp_f.check_byte), 16'(got.check_byte));
        endfunction
    endclass

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_hrfp_in  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_hrfp_out out_data;

    hrfp_frame_checker sb = new();

    int  words_sent     = 0;
    int  words_taken    = 0;
    int  stall_cycles   = 0;
    bit  idle_on        = 1'b1;
    int  send_gap_pct   = 0;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    hex_request_frame_parser dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    // handshake monitor and stall counter
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && in_ready) begin
                sb.note_word(in_data);
                words_taken++;
            end
            if (out_valid && out_ready)
                sb.check_frame(out_data);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
    end

    initial begin
        while (stall_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("tb_hex_request_frame_parser: FAIL");
        $finish;
    end

    // result side: random stall bursts, one long hold-off to back up the input
    initial begin
        int  stall_pct;
        bit  long_hold_done;
        stall_pct      = 0;
        long_hold_done = 1'b0;
        forever begin
            @(negedge clk);
            if ($urandom_range(0, 49) == 0)
                stall_pct = $urandom_range(0, 2) * 15;
            if (!long_hold_done && words_taken >= HOLD_AFTER) begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge clk);
                long_hold_done = 1'b1;
            end else if (idle_on && $urandom_range(1, 100) <= stall_pct) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(0, 5)) @(negedge clk);
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    task automatic send_word(input logic [7:0] c, input logic s);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(1, 100) <= send_gap_pct)
            gap = $urandom_range(1, 6);
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{char_code: c, frame_start: s};
        do @(posedge clk); while (!in_ready);
        words_sent++;
    endtask

    task automatic send_text(input string txt, input bit with_start);
        for (int i = 0; i < txt.len(); i++)
            send_word(txt[i], with_start && i == 0);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit lower);
        if (8'(nib) < HEX_TEN)
            return CH_DIGIT_0 + 8'(nib);
        return (lower ? CH_LOWER_A : CH_UPPER_A) + 8'(nib) - HEX_TEN;
    endfunction

    // mostly hex digits of either case, now and then a non-hex or arbitrary byte
    function automatic logic [7:0] body_char();
        if ($urandom_range(0, 24) == 0) begin
            if ($urandom_range(0, 1) == 0)
                return NEAR_HEX[$urandom_range(0, 5)];
            return 8'($urandom_range(0, 255));
        end
        return hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
    endfunction

    initial begin
        int kind;
        int len;
        int frames_sent;
        frames_sent = 0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // no start since reset: taken as a frame; count field and check byte invalid
        send_text("09AFaf09", 1'b0);
        send_word(8'hFF, 1'b0);
        send_text("FFF", 1'b0);
        send_text("`7", 1'b0);
        // past the 14th word: ignored
        send_word(8'h00, 1'b0);
        // partial frame dropped by the next start
        send_text("3A@:", 1'b1);
        send_text("fF00FfFf0000a9", 1'b1);

        while (words_sent < RANDOM_WORDS || frames_sent < MIN_FRAMES) begin
            if (words_sent >= QUIET_AFTER)
                idle_on = 1'b0;
            send_gap_pct = $urandom_range(0, 2) * 15;
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                for (int i = 0; i < 14; i++)
                    send_word(body_char(), i == 0);
                frames_sent++;
                if ($urandom_range(0, 2) == 0) begin
                    len = $urandom_range(1, 3);
                    for (int i = 0; i < len; i++)
                        send_word(8'($urandom_range(0, 255)), 1'b0);
                end
            end else if (kind < 85) begin
                len = $urandom_range(1, 13);
                for (int i = 0; i < len; i++)
                    send_word(body_char(), i == 0);
            end else begin
                len = $urandom_range(1, 5);
                for (int i = 0; i < len; i++)
                    send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end
        end
        @(negedge clk);
        in_valid <= 1'b0;

        while (sb.frames_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.fail_count == 0)
            $display("tb_hex_request_frame_parser: PASS");
        else
            $display("tb_hex_request_frame_parser: FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/hrfp_pkg.sv
rtl/hrfp_nibble_dec.sv
rtl/hex_request_frame_parser.sv
tb/sv/tb_hex_request_frame_parser.sv
